// ----- rtl/page_frame_lru_pin_manager_core_defines.svh -----
// ----------------------------------------------------------------------------
// Page frame manager assertion macros
// Shared assertion helpers for the page frame manager.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_LRU_PIN_MANAGER_CORE_DEFINES_SVH
`define PAGE_FRAME_LRU_PIN_MANAGER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PFLM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PFLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pflm_pkg.sv -----
// ----------------------------------------------------------------------------
// Page frame manager package
// Sizes, request and status codes, state and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pflm_pkg;

    localparam int FRAMES   = 64;
    localparam int IDX_W    = $clog2(FRAMES);
    localparam int PIN_BITS = 8;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [PIN_BITS-1:0] t_pin;

    localparam t_pin PIN_MAX   = {PIN_BITS{1'b1}};
    localparam t_idx IDX_LAST  = t_idx'(FRAMES - 1);

    localparam logic [2:0] REQ_ACCESS = 3'd0;
    localparam logic [2:0] REQ_PIN    = 3'd1;
    localparam logic [2:0] REQ_UNPIN  = 3'd2;
    localparam logic [2:0] REQ_DIRTY  = 3'd3;
    localparam logic [2:0] REQ_DROP   = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_RES   = 2'd1;
    localparam logic [1:0] STS_ALL_PIN   = 2'd2;
    localparam logic [1:0] STS_UNDERFLOW = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

// ----- rtl/page_frame_lru_pin_manager_core.sv -----
// The request is captured in ST_IDLE, all frames are scanned in ST_SCAN, the result is
// applied in ST_APPLY and o_valid is registered from it; busy is high until o_valid rises.
// No request is taken while busy. The scan reads one frame per cycle and compares it in the following cycle.
// Reset is synchronous and active low: all frames invalid, unpinned, frame i rank i.
// The result strobe o_valid lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Page frame manager top level
// LRU page frame manager with pinning, dirty tracking and file drop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_frame_lru_pin_manager_core_defines.svh"

module page_frame_lru_pin_manager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_file_id,
    input  logic [31:0] i_block_num,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_frame,
    output logic        o_hit,
    output logic        o_fetch_needed,
    output logic        o_writeback_needed,
    output logic [15:0] o_writeback_file,
    output logic [31:0] o_writeback_block
);

    pflm_pkg::t_cmd   cmd;
    pflm_pkg::t_stat  stat;
    pflm_pkg::t_state state;

    pflm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_state (state)
    );

    pflm_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_req_type         (i_req_type),
        .i_file_id          (i_file_id),
        .i_block_num        (i_block_num),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_frame            (o_frame),
        .o_hit              (o_hit),
        .o_fetch_needed     (o_fetch_needed),
        .o_writeback_needed (o_writeback_needed),
        .o_writeback_file   (o_writeback_file),
        .o_writeback_block  (o_writeback_block)
    );

    `PFLM_ASSERT_NEXT(a_apply_strobe, state == pflm_pkg::ST_APPLY, o_valid, "apply without strobe")
    `PFLM_ASSERT_IMP(a_wb_miss, o_valid && o_writeback_needed, o_fetch_needed && !o_hit, "write-back without miss")
    `PFLM_ASSERT_IMP(a_all_pinned, o_valid && (o_status == pflm_pkg::STS_ALL_PIN), !o_hit && !o_fetch_needed && (o_frame == '0), "all-pinned result not cleared")

endmodule

// ----- rtl/pflm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Page frame manager controller
// Sequences request capture, the frame scan and the result update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pflm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pflm_pkg::t_stat  i_stat,
    output pflm_pkg::t_cmd   o_cmd,
    output logic             busy,
    output pflm_pkg::t_state o_state
);

    pflm_pkg::t_state r_state;
    pflm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pflm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pflm_pkg::ST_IDLE: begin
                if (start) n_state = pflm_pkg::ST_SCAN;
            end
            pflm_pkg::ST_SCAN: begin
                if (i_stat.last) n_state = pflm_pkg::ST_APPLY;
            end
            pflm_pkg::ST_APPLY: begin
                n_state = pflm_pkg::ST_IDLE;
            end
            default: n_state = pflm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            pflm_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            pflm_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            pflm_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    assign o_state = r_state;

endmodule

// ----- rtl/pflm_datapath.sv -----
// ----------------------------------------------------------------------------
// Page frame manager datapath
// Frame table, recency ranks, scan registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pflm_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pflm_pkg::t_cmd        i_cmd,
    output pflm_pkg::t_stat       o_stat,
    input  logic [2:0]            i_req_type,
    input  logic [15:0]           i_file_id,
    input  logic [31:0]           i_block_num,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [5:0]            o_frame,
    output logic                  o_hit,
    output logic                  o_fetch_needed,
    output logic                  o_writeback_needed,
    output logic [15:0]           o_writeback_file,
    output logic [31:0]           o_writeback_block
);

    // Frame table.
    logic                 r_fvalid [pflm_pkg::FRAMES];
    logic                 r_fdirty [pflm_pkg::FRAMES];
    pflm_pkg::t_pin       r_pin    [pflm_pkg::FRAMES];
    logic [15:0]          r_tfile  [pflm_pkg::FRAMES];
    logic [31:0]          r_tblk   [pflm_pkg::FRAMES];
    pflm_pkg::t_idx       r_rank   [pflm_pkg::FRAMES];
    pflm_pkg::t_idx       n_rank   [pflm_pkg::FRAMES];

    // Request registers.
    logic [2:0]           r_type;
    logic [15:0]          r_fid;
    logic [31:0]          r_blk;

    // Scan pipeline: read stage and compare stage.
    pflm_pkg::t_idx       r_ridx;
    logic                 r_cvld;
    pflm_pkg::t_idx       r_cidx;
    logic                 r_rd_valid;
    logic                 r_rd_dirty;
    pflm_pkg::t_pin       r_rd_pin;
    logic [15:0]          r_rd_file;
    logic [31:0]          r_rd_blk;
    pflm_pkg::t_idx       r_rd_rank;
    logic                 r_pdrop;
    pflm_pkg::t_idx       r_prank;

    // Scan results.
    logic                 r_found;
    pflm_pkg::t_idx       r_hidx;
    pflm_pkg::t_pin       r_hpin;
    pflm_pkg::t_idx       r_hrank;
    logic                 r_vfound;
    pflm_pkg::t_idx       r_vidx;
    pflm_pkg::t_idx       r_vrank;
    logic                 r_vvalid;
    logic                 r_vdirty;
    logic [15:0]          r_vfile;
    logic [31:0]          r_vblk;

    // Result register.
    logic                 r_o_valid;
    logic [1:0]           r_o_status;
    pflm_pkg::t_idx       r_o_frame;
    logic                 r_o_hit;
    logic                 r_o_fetch;
    logic                 r_o_wb;
    logic [15:0]          r_o_wbfile;
    logic [31:0]          r_o_wbblk;

    logic                 scan_en;
    pflm_pkg::t_idx       cur_rank;
    logic                 cur_match;
    logic                 cur_drop;
    logic                 cur_cand;
    logic                 is_obt;
    logic                 is_dirty;
    logic                 ok_obt;
    pflm_pkg::t_idx       tgt;
    pflm_pkg::t_idx       tgt_rank;
    pflm_pkg::t_pin       pin_cur;
    pflm_pkg::t_pin       pin_new;
    logic                 mru_apply;
    logic                 upd_mru;
    logic                 upd_lru;
    pflm_pkg::t_idx       upd_sel;
    pflm_pkg::t_idx       sel_rank;
    logic [1:0]           n_status;
    logic                 wb_need;

    assign o_stat.last = r_cvld && (r_cidx == pflm_pkg::IDX_LAST);

    always_comb begin
        scan_en   = i_cmd.scan && r_cvld;
        // The rank was read at the edge where the previous frame was dropped to LRU,
        // so it takes that shift here.
        cur_rank  = (r_pdrop && (r_rd_rank < r_prank)) ? r_rd_rank + 1'b1 : r_rd_rank;
        cur_match = r_rd_valid && (r_rd_file == r_fid) && (r_rd_blk == r_blk);
        cur_drop  = (r_type == pflm_pkg::REQ_DROP) && r_rd_valid && (r_rd_file == r_fid);
        cur_cand  = (r_rd_pin == '0) && (!r_vfound || (cur_rank < r_vrank));
    end

    always_comb begin
        is_obt   = (r_type == pflm_pkg::REQ_ACCESS) || (r_type == pflm_pkg::REQ_PIN)
                   || (r_type == pflm_pkg::REQ_UNPIN);
        is_dirty = (r_type == pflm_pkg::REQ_DIRTY);
        ok_obt   = is_obt && (r_found || r_vfound);
        tgt      = r_found ? r_hidx : r_vidx;
        tgt_rank = r_found ? r_hrank : r_vrank;
        pin_cur  = r_found ? r_hpin : '0;
        pin_new  = pin_cur;
        if (r_type == pflm_pkg::REQ_PIN) begin
            pin_new = (pin_cur == pflm_pkg::PIN_MAX) ? pin_cur : pin_cur + 1'b1;
        end else if (r_type == pflm_pkg::REQ_UNPIN) begin
            pin_new = (pin_cur == '0) ? pin_cur : pin_cur - 1'b1;
        end
        // A miss always installs at MRU; a hit moves only when the frame ends unpinned.
        mru_apply = ok_obt && (!r_found
                    || ((r_type == pflm_pkg::REQ_ACCESS) && (pin_cur == '0))
                    || ((r_type == pflm_pkg::REQ_UNPIN)
                        && (pin_cur == pflm_pkg::t_pin'(1))));
        wb_need   = ok_obt && !r_found && r_vvalid && r_vdirty;
        n_status  = pflm_pkg::STS_OK;
        if (is_obt) begin
            if (!ok_obt) begin
                n_status = pflm_pkg::STS_ALL_PIN;
            end else if ((r_type == pflm_pkg::REQ_UNPIN) && (pin_cur == '0)) begin
                n_status = pflm_pkg::STS_UNDERFLOW;
            end
        end else if (is_dirty && !r_found) begin
            n_status = pflm_pkg::STS_NOT_RES;
        end
    end

    // Recency update: one frame moves to an end, the others between shift by one.
    always_comb begin
        upd_mru  = i_cmd.apply && mru_apply;
        upd_lru  = scan_en && cur_drop;
        upd_sel  = i_cmd.apply ? tgt : r_cidx;
        sel_rank = i_cmd.apply ? tgt_rank : cur_rank;
        for (int j = 0; j < pflm_pkg::FRAMES; j++) begin
            n_rank[j] = r_rank[j];
            if (upd_mru) begin
                if (pflm_pkg::t_idx'(j) == upd_sel) begin
                    n_rank[j] = pflm_pkg::IDX_LAST;
                end else if (r_rank[j] > sel_rank) begin
                    n_rank[j] = r_rank[j] - 1'b1;
                end
            end else if (upd_lru) begin
                if (pflm_pkg::t_idx'(j) == upd_sel) begin
                    n_rank[j] = '0;
                end else if (r_rank[j] < sel_rank) begin
                    n_rank[j] = r_rank[j] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < pflm_pkg::FRAMES; j++) begin
                r_fvalid[j] <= 1'b0;
                r_fdirty[j] <= 1'b0;
                r_pin[j]    <= '0;
                r_rank[j]   <= pflm_pkg::t_idx'(j);
            end
        end else begin
            for (int j = 0; j < pflm_pkg::FRAMES; j++) begin
                r_rank[j] <= n_rank[j];
            end
            if (scan_en && cur_drop) begin
                r_fvalid[r_cidx] <= 1'b0;
                r_fdirty[r_cidx] <= 1'b0;
                r_pin[r_cidx]    <= '0;
            end
            if (i_cmd.apply) begin
                if (ok_obt) begin
                    r_pin[tgt] <= pin_new;
                    if (!r_found) begin
                        r_fvalid[tgt] <= 1'b1;
                        r_fdirty[tgt] <= 1'b0;
                    end
                end else if (is_dirty && r_found) begin
                    r_fdirty[r_hidx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && ok_obt && !r_found) begin
            r_tfile[tgt] <= r_fid;
            r_tblk[tgt]  <= r_blk;
        end
        if (i_cmd.scan) begin
            r_rd_file <= r_tfile[r_ridx];
            r_rd_blk  <= r_tblk[r_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx   <= '0;
            r_cvld   <= 1'b0;
            r_pdrop  <= 1'b0;
            r_found  <= 1'b0;
            r_vfound <= 1'b0;
        end else if (i_cmd.load) begin
            r_ridx   <= '0;
            r_cvld   <= 1'b0;
            r_pdrop  <= 1'b0;
            r_found  <= 1'b0;
            r_vfound <= 1'b0;
        end else if (i_cmd.scan) begin
            r_ridx  <= r_ridx + 1'b1;
            r_cvld  <= 1'b1;
            r_pdrop <= r_cvld && cur_drop;
            if (r_cvld && !r_found && cur_match) begin
                r_found <= 1'b1;
            end
            if (r_cvld && cur_cand) begin
                r_vfound <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_fid  <= i_file_id;
            r_blk  <= i_block_num;
        end
        if (i_cmd.scan) begin
            r_cidx     <= r_ridx;
            r_rd_valid <= r_fvalid[r_ridx];
            r_rd_dirty <= r_fdirty[r_ridx];
            r_rd_pin   <= r_pin[r_ridx];
            r_rd_rank  <= r_rank[r_ridx];
            r_prank    <= cur_rank;
            if (r_cvld) begin
                if (!r_found && cur_match) begin
                    r_hidx  <= r_cidx;
                    r_hpin  <= r_rd_pin;
                    r_hrank <= cur_rank;
                end
                if (cur_cand) begin
                    r_vidx   <= r_cidx;
                    r_vrank  <= cur_rank;
                    r_vvalid <= r_rd_valid;
                    r_vdirty <= r_rd_dirty;
                    r_vfile  <= r_rd_file;
                    r_vblk   <= r_rd_blk;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_o_status <= n_status;
            r_o_frame  <= ok_obt ? tgt : ((is_dirty && r_found) ? r_hidx : '0);
            r_o_hit    <= (ok_obt || is_dirty) && r_found;
            r_o_fetch  <= ok_obt && !r_found;
            r_o_wb     <= wb_need;
            r_o_wbfile <= wb_need ? r_vfile : '0;
            r_o_wbblk  <= wb_need ? r_vblk : '0;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_status           = r_o_status;
    assign o_frame            = 6'(r_o_frame);
    assign o_hit              = r_o_hit;
    assign o_fetch_needed     = r_o_fetch;
    assign o_writeback_needed = r_o_wb;
    assign o_writeback_file   = r_o_wbfile;
    assign o_writeback_block  = r_o_wbblk;

endmodule

// ----- tb/sv/page_frame_lru_pin_manager_core_test.sv -----
// ----------------------------------------------------------------------------
// Page frame manager testbench
// Drives lookup, pin, unpin, dirty, drop and undefined requests through the start/busy
// handshake and checks every result against a behavioral LRU frame table or a fixed expected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_lru_pin_manager_core_test;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  frame;
        logic        hit;
        logic        fetch;
        logic        wb;
        logic [15:0] wb_file;
        logic [31:0] wb_block;
    } t_res;

    typedef struct {
        logic [2:0]  rtype;
        logic [15:0] fid;
        logic [31:0] blk;
        int          reps;
        int          blk_step;
        bit          typed;
        t_res        res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_req_type;
    logic [15:0] i_file_id;
    logic [31:0] i_block_num;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [5:0]  o_frame;
    logic        o_hit;
    logic        o_fetch_needed;
    logic        o_writeback_needed;
    logic [15:0] o_writeback_file;
    logic [31:0] o_writeback_block;

    page_frame_lru_pin_manager_core dut (.*);

    // Behavioral copy of the frame table.
    bit             fr_valid [pflm_pkg::FRAMES];
    bit             fr_dirty [pflm_pkg::FRAMES];
    pflm_pkg::t_pin fr_pins  [pflm_pkg::FRAMES];
    logic [15:0]    fr_file  [pflm_pkg::FRAMES];
    logic [31:0]    fr_block [pflm_pkg::FRAMES];
    int             fr_rank  [pflm_pkg::FRAMES];

    t_res pending_results[$];
    t_row stim_table[$];
    int   mismatches;
    int   cycles;
    int   idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void make_recent(int f);
        int r;
        r = fr_rank[f];
        for (int j = 0; j < pflm_pkg::FRAMES; j++)
            if (fr_rank[j] > r) fr_rank[j]--;
        fr_rank[f] = pflm_pkg::FRAMES - 1;
    endfunction

    function automatic void make_oldest(int f);
        int r;
        r = fr_rank[f];
        for (int j = 0; j < pflm_pkg::FRAMES; j++)
            if (fr_rank[j] < r) fr_rank[j]++;
        fr_rank[f] = 0;
    endfunction

    function automatic int find_frame(logic [15:0] fid, logic [31:0] blk);
        for (int j = 0; j < pflm_pkg::FRAMES; j++)
            if (fr_valid[j] && fr_file[j] == fid && fr_block[j] == blk) return j;
        return -1;
    endfunction

    function automatic t_res predict_request(logic [2:0] rtype, logic [15:0] fid,
                                             logic [31:0] blk);
        t_res r;
        int   f;
        int   victim;
        r = '0;
        victim = -1;
        if (rtype == pflm_pkg::REQ_ACCESS || rtype == pflm_pkg::REQ_PIN
            || rtype == pflm_pkg::REQ_UNPIN) begin
            f = find_frame(fid, blk);
            if (f >= 0) begin
                if (rtype == pflm_pkg::REQ_ACCESS && fr_pins[f] == 0) make_recent(f);
                r.hit = 1'b1;
            end else begin
                for (int j = 0; j < pflm_pkg::FRAMES; j++)
                    if (fr_pins[j] == 0 && (victim < 0 || fr_rank[j] < fr_rank[victim]))
                        victim = j;
                if (victim < 0) begin
                    r.status = pflm_pkg::STS_ALL_PIN;
                    return r;
                end
                if (fr_valid[victim] && fr_dirty[victim]) begin
                    r.wb       = 1'b1;
                    r.wb_file  = fr_file[victim];
                    r.wb_block = fr_block[victim];
                end
                fr_valid[victim] = 1'b1;
                fr_dirty[victim] = 1'b0;
                fr_file[victim]  = fid;
                fr_block[victim] = blk;
                make_recent(victim);
                r.fetch = 1'b1;
                f = victim;
            end
            r.frame = f[5:0];
            if (rtype == pflm_pkg::REQ_PIN) begin
                if (fr_pins[f] != pflm_pkg::PIN_MAX) fr_pins[f]++;
            end else if (rtype == pflm_pkg::REQ_UNPIN) begin
                if (fr_pins[f] == 0) begin
                    r.status = pflm_pkg::STS_UNDERFLOW;
                end else begin
                    fr_pins[f]--;
                    if (fr_pins[f] == 0) make_recent(f);
                end
            end
        end else if (rtype == pflm_pkg::REQ_DIRTY) begin
            f = find_frame(fid, blk);
            if (f < 0) begin
                r.status = pflm_pkg::STS_NOT_RES;
            end else begin
                fr_dirty[f] = 1'b1;
                r.frame = f[5:0];
                r.hit   = 1'b1;
            end
        end else if (rtype == pflm_pkg::REQ_DROP) begin
            for (int j = 0; j < pflm_pkg::FRAMES; j++)
                if (fr_valid[j] && fr_file[j] == fid) begin
                    fr_valid[j] = 1'b0;
                    fr_dirty[j] = 1'b0;
                    fr_pins[j]  = '0;
                    make_oldest(j);
                end
        end
        return r;
    endfunction

    // Holds start high until the request is taken; start stays high afterwards
    // so that a back-to-back request needs no second assignment in one step.
    task automatic issue(logic [2:0] rtype, logic [15:0] fid, logic [31:0] blk,
                         bit typed, t_res typed_res);
        t_res p;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= rtype;
        i_file_id   <= fid;
        i_block_num <= blk;
        do @(posedge i_clk); while (busy);
        p = predict_request(rtype, fid, blk);
        pending_results = {pending_results, (typed ? typed_res : p)};
    endtask

    task automatic add_row(logic [2:0] rtype, logic [15:0] fid, logic [31:0] blk,
                           int reps, int blk_step, bit typed, logic [1:0] st,
                           logic [5:0] fr, logic hit, logic fetch);
        t_row row;
        row.rtype = rtype; row.fid = fid; row.blk = blk;
        row.reps = reps; row.blk_step = blk_step; row.typed = typed;
        row.res = '{status: st, frame: fr, hit: hit, fetch: fetch, default: '0};
        stim_table = {stim_table, row};
    endtask

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("page_frame_lru_pin_manager_core_test: done, errors");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            got = '{o_status, o_frame, o_hit, o_fetch_needed, o_writeback_needed,
                    o_writeback_file, o_writeback_block};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        logic [2:0]  rtype;
        logic [15:0] fid;
        logic [31:0] blk;
        int          pick;
        int          waited;
        cycles      = 0;
        mismatches  = 0;
        idle_pct    = 38;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = pflm_pkg::REQ_ACCESS;
        i_file_id   = '0;
        i_block_num = '0;
        for (int j = 0; j < pflm_pkg::FRAMES; j++) begin
            fr_valid[j] = 0; fr_dirty[j] = 0; fr_pins[j] = '0;
            fr_file[j] = '0; fr_block[j] = '0; fr_rank[j] = j;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fresh table fills from frame 0 upward.
        add_row(pflm_pkg::REQ_ACCESS, 16'h0000, 32'h0000_0000, 1, 0, 1,
                pflm_pkg::STS_OK, 6'd0, 0, 1);
        add_row(pflm_pkg::REQ_ACCESS, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 1,
                pflm_pkg::STS_OK, 6'd1, 0, 1);
        add_row(pflm_pkg::REQ_DIRTY,  16'h1234, 32'h0000_0005, 1, 0, 1,
                pflm_pkg::STS_NOT_RES, 6'd0, 0, 0);
        add_row(pflm_pkg::REQ_DIRTY,  16'h0000, 32'h0000_0000, 1, 0, 1,
                pflm_pkg::STS_OK, 6'd0, 1, 0);
        add_row(pflm_pkg::REQ_UNPIN,  16'h0000, 32'h0000_0000, 1, 0, 1,
                pflm_pkg::STS_UNDERFLOW, 6'd0, 1, 0);
        add_row(pflm_pkg::REQ_PIN,    16'hFFFF, 32'hFFFF_FFFF, 1, 0, 1,
                pflm_pkg::STS_OK, 6'd1, 1, 0);
        add_row(pflm_pkg::REQ_UNPIN,  16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0, 0);
        add_row(pflm_pkg::REQ_DROP,   16'h0000, 32'hDEAD_BEEF, 1, 0, 1,
                pflm_pkg::STS_OK, 6'd0, 0, 0);
        add_row(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 1, pflm_pkg::STS_OK, 6'd0, 0, 0);
        add_row(3'd6, 16'h00FF, 32'h0000_FFFF, 1, 0, 1, pflm_pkg::STS_OK, 6'd0, 0, 0);
        add_row(3'd7, 16'hFF00, 32'hFFFF_0000, 1, 0, 1, pflm_pkg::STS_OK, 6'd0, 0, 0);
        // Pin count runs into saturation, then back down through zero.
        add_row(pflm_pkg::REQ_PIN,    16'h0007, 32'h0000_0007, 260, 0, 0, 0, 0, 0, 0);
        add_row(pflm_pkg::REQ_UNPIN,  16'h0007, 32'h0000_0007, 257, 0, 0, 0, 0, 0, 0);
        // Dirty pages are evicted by a sweep of fresh pages.
        add_row(pflm_pkg::REQ_DIRTY,  16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0, 0);
        add_row(pflm_pkg::REQ_ACCESS, 16'h0002, 32'h0000_0000, 70, 1, 0, 0, 0, 0, 0);
        // Pin every frame, then a miss has nowhere to go.
        add_row(pflm_pkg::REQ_PIN,    16'h0009, 32'h0000_0000, 64, 1, 0, 0, 0, 0, 0);
        add_row(pflm_pkg::REQ_ACCESS, 16'h0009, 32'h8000_0000, 1, 0, 1,
                pflm_pkg::STS_ALL_PIN, 6'd0, 0, 0);
        add_row(pflm_pkg::REQ_UNPIN,  16'h0009, 32'h8000_0000, 1, 0, 1,
                pflm_pkg::STS_ALL_PIN, 6'd0, 0, 0);
        add_row(pflm_pkg::REQ_DROP,   16'h0009, 32'h0000_0000, 1, 0, 1,
                pflm_pkg::STS_OK, 6'd0, 0, 0);
        add_row(pflm_pkg::REQ_DROP,   16'h0002, 32'h0000_0000, 1, 0, 1,
                pflm_pkg::STS_OK, 6'd0, 0, 0);

        foreach (stim_table[k])
            for (int n = 0; n < stim_table[k].reps; n++)
                issue(stim_table[k].rtype, stim_table[k].fid,
                      stim_table[k].blk + 32'(n * stim_table[k].blk_step),
                      stim_table[k].typed, stim_table[k].res);

        // A small page pool keeps hits, pins and evictions all frequent.
        for (int n = 0; n < 840; n++) begin
            idle_pct = (n < 280) ? 38 : (n < 560) ? 55 : 0;
            pick = $urandom_range(99);
            if (pick < 40)      rtype = pflm_pkg::REQ_ACCESS;
            else if (pick < 55) rtype = pflm_pkg::REQ_PIN;
            else if (pick < 70) rtype = pflm_pkg::REQ_UNPIN;
            else if (pick < 88) rtype = pflm_pkg::REQ_DIRTY;
            else if (pick < 93) rtype = pflm_pkg::REQ_DROP;
            else if (pick < 96) rtype = 3'($urandom_range(5, 7));
            else                rtype = pflm_pkg::REQ_ACCESS;
            fid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            blk = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(40));
            issue(rtype, fid, blk, 0, '0);
        end
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("page_frame_lru_pin_manager_core_test: done, clean");
        else
            $display("page_frame_lru_pin_manager_core_test: done, errors");
        $finish;
    end

endmodule
